>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising edge outside reset
`define DLLS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that a condition never holds outside reset
`define DLLS_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> sv/dlls_pkg.sv
package dlls_pkg;

    localparam int CAPACITY = 16;
    localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 8;
    localparam int VAL_W    = 32;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [2:0] {
        CMD_APPEND  = 3'd0,
        CMD_PREPEND = 3'd1,
        CMD_DELETE  = 3'd2,
        CMD_CLEAR   = 3'd3,
        CMD_READ    = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DEL_WALK,
        S_RD_WALK
    } t_state;

    typedef struct packed {
        logic [2:0]              command;
        logic signed [VAL_W-1:0] item_value;
        logic [POS_W-1:0]        position;
    } t_in;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [VAL_W-1:0] read_value;
        logic                    last;
    } t_out;

    typedef struct packed {
        logic    load;
        logic    insert;
        logic    at_head;
        logic    clear;
        logic    advance;
        logic    unlink;
        logic    emit;
        t_status emit_status;
        logic    emit_value;
        logic    emit_last;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] command;
        logic       empty;
        logic       full;
        logic       pos_out;
        logic       at_pos;
        logic       at_last;
    } t_dp_stat;

endpackage

>>> sv/dlls_datapath.sv
module dlls_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dlls_pkg::t_in      i_item,
    input  dlls_pkg::t_dp_cmd  i_cmd,
    output dlls_pkg::t_dp_stat o_stat,
    output logic               o_strobe,
    output dlls_pkg::t_out     o_result
);
    import dlls_pkg::*;

    logic signed [VAL_W-1:0] m_value [CAPACITY];
    logic [SLOT_W-1:0]       m_next  [CAPACITY];
    logic [SLOT_W-1:0]       m_prev  [CAPACITY];

    t_in                     r_item;
    logic [SLOT_W-1:0]       r_head;
    logic [SLOT_W-1:0]       r_tail;
    logic [CNT_W-1:0]        r_count;
    logic [CAPACITY-1:0]     r_free;
    logic [SLOT_W-1:0]       r_cur;
    logic [SLOT_W-1:0]       n_cur;
    logic [SLOT_W-1:0]       r_idx;
    logic signed [VAL_W-1:0] r_val_q;
    logic [SLOT_W-1:0]       r_next_q;
    logic [SLOT_W-1:0]       r_prev_q;
    logic                    r_strobe;
    t_out                    r_result;

    logic [SLOT_W-1:0] free_slot;
    logic              single;
    logic              pos_zero;
    logic              at_last;
    logic              val_we;
    logic              next_we;
    logic              prev_we;
    logic [SLOT_W-1:0] val_addr;
    logic [SLOT_W-1:0] next_addr;
    logic [SLOT_W-1:0] prev_addr;
    logic [SLOT_W-1:0] next_data;
    logic [SLOT_W-1:0] prev_data;

    always_comb begin
        free_slot = '0;
        for (int k = CAPACITY - 1; k >= 0; k--) begin
            if (r_free[k]) begin
                free_slot = SLOT_W'(k);
            end
        end
    end

    assign single   = (r_count == CNT_W'(1));
    assign pos_zero = (r_idx == '0);
    assign at_last  = (CNT_W'(r_idx) == r_count - CNT_W'(1));

    assign o_stat.command = r_item.command;
    assign o_stat.empty   = (r_count == '0);
    assign o_stat.full    = (r_count == CNT_W'(CAPACITY));
    assign o_stat.pos_out = (CMP_W'(r_item.position) >= CMP_W'(r_count));
    assign o_stat.at_pos  = (CMP_W'(r_idx) == CMP_W'(r_item.position));
    assign o_stat.at_last = at_last;

    always_comb begin
        n_cur = r_cur;
        if (i_cmd.load) begin
            n_cur = r_head;
        end else if (i_cmd.advance) begin
            n_cur = r_next_q;
        end
    end

    always_comb begin
        val_we    = 1'b0;
        next_we   = 1'b0;
        prev_we   = 1'b0;
        val_addr  = free_slot;
        next_addr = '0;
        prev_addr = '0;
        next_data = '0;
        prev_data = '0;
        if (i_cmd.insert) begin
            val_we = 1'b1;
            if (r_count != '0) begin
                if (i_cmd.at_head) begin
                    next_we   = 1'b1;
                    next_addr = free_slot;
                    next_data = r_head;
                    prev_we   = 1'b1;
                    prev_addr = r_head;
                    prev_data = free_slot;
                end else begin
                    prev_we   = 1'b1;
                    prev_addr = free_slot;
                    prev_data = r_tail;
                    next_we   = 1'b1;
                    next_addr = r_tail;
                    next_data = free_slot;
                end
            end
        end
        if (i_cmd.unlink && !single) begin
            if (!pos_zero) begin
                next_we   = 1'b1;
                next_addr = r_prev_q;
                next_data = r_next_q;
            end
            if (!at_last) begin
                prev_we   = 1'b1;
                prev_addr = r_next_q;
                prev_data = r_prev_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (val_we) begin
            m_value[val_addr] <= r_item.item_value;
        end
        if (next_we) begin
            m_next[next_addr] <= next_data;
        end
        if (prev_we) begin
            m_prev[prev_addr] <= prev_data;
        end
        r_val_q  <= m_value[n_cur];
        r_next_q <= m_next[n_cur];
        r_prev_q <= m_prev[n_cur];
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        if (i_cmd.load) begin
            r_item <= i_item;
            r_idx  <= '0;
        end else if (i_cmd.advance) begin
            r_idx <= r_idx + SLOT_W'(1);
        end
        r_result.status     <= i_cmd.emit_status;
        r_result.read_value <= i_cmd.emit_value ? r_val_q : '0;
        r_result.last       <= i_cmd.emit_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_free   <= {CAPACITY{1'b1}};
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
            if (i_cmd.clear) begin
                r_head  <= '0;
                r_tail  <= '0;
                r_count <= '0;
                r_free  <= {CAPACITY{1'b1}};
            end else if (i_cmd.insert) begin
                r_free[free_slot] <= 1'b0;
                r_count           <= r_count + CNT_W'(1);
                if (r_count == '0) begin
                    r_head <= free_slot;
                    r_tail <= free_slot;
                end else if (i_cmd.at_head) begin
                    r_head <= free_slot;
                end else begin
                    r_tail <= free_slot;
                end
            end else if (i_cmd.unlink) begin
                r_free[r_cur] <= 1'b1;
                r_count       <= r_count - CNT_W'(1);
                if (single) begin
                    r_head <= '0;
                    r_tail <= '0;
                end else begin
                    if (pos_zero) begin
                        r_head <= r_next_q;
                    end
                    if (at_last) begin
                        r_tail <= r_prev_q;
                    end
                end
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

>>> sv/dlls_ctrl.sv
module dlls_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  dlls_pkg::t_dp_stat i_stat,
    output dlls_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy
);
    import dlls_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state         = S_IDLE;
                cmd.emit        = 1'b1;
                cmd.emit_last   = 1'b1;
                cmd.emit_status = ST_OK;
                case (i_stat.command)
                    CMD_APPEND, CMD_PREPEND: begin
                        if (i_stat.full) begin
                            cmd.emit_status = ST_FULL;
                        end else begin
                            cmd.insert  = 1'b1;
                            cmd.at_head = (i_stat.command == CMD_PREPEND);
                        end
                    end
                    CMD_DELETE: begin
                        if (i_stat.empty) begin
                            cmd.emit_status = ST_EMPTY;
                        end else if (i_stat.pos_out) begin
                            cmd.emit_status = ST_NOT_FOUND;
                        end else begin
                            cmd.emit      = 1'b0;
                            cmd.emit_last = 1'b0;
                            n_state       = S_DEL_WALK;
                        end
                    end
                    CMD_CLEAR: begin
                        cmd.clear = 1'b1;
                    end
                    CMD_READ: begin
                        if (i_stat.empty) begin
                            cmd.emit_status = ST_EMPTY;
                        end else begin
                            cmd.emit      = 1'b0;
                            cmd.emit_last = 1'b0;
                            n_state       = S_RD_WALK;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_DEL_WALK: begin
                if (i_stat.at_pos) begin
                    cmd.unlink      = 1'b1;
                    cmd.emit        = 1'b1;
                    cmd.emit_last   = 1'b1;
                    cmd.emit_status = ST_OK;
                    n_state         = S_IDLE;
                end else begin
                    cmd.advance = 1'b1;
                end
            end
            S_RD_WALK: begin
                cmd.emit        = 1'b1;
                cmd.emit_value  = 1'b1;
                cmd.emit_status = ST_OK;
                cmd.emit_last   = i_stat.at_last;
                cmd.advance     = 1'b1;
                if (i_stat.at_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

>>> sv/bounded_doubly_linked_list_store_core.sv
// Channel   Direction  Handshake            Payload
// command   in         start high, busy low i_item   (command, item_value, position)
// result    out        o_strobe, one cycle  o_result (status, read_value, last)
//
// Append, prepend, clear and unused codes: busy in execute only, result registered from it.
// Delete: walks to position and unlinks; rejected (empty or not found) in execute only.
// Read out: busy while the walk emits each entry, head to tail; empty list: execute only.
// The link walk follows one slot per cycle through a single registered read of the links.
// Synchronous active-low reset empties the list; slot contents stay undefined until written.
// Results cannot be stalled; each strobe lasts one cycle.
`include "assert_macros.svh"

module bounded_doubly_linked_list_store_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  dlls_pkg::t_in  i_item,
    output logic           busy,
    output logic           o_strobe,
    output dlls_pkg::t_out o_result
);
    import dlls_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    dlls_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    dlls_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (dp_cmd),
        .o_stat   (dp_stat),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    `DLLS_ASSERT(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "accept without busy")
    `DLLS_NEVER(a_err_last, i_clk, i_rst_n, o_strobe && (o_result.status != ST_OK) && !o_result.last, "error result not last")
    `DLLS_ASSERT(a_mid_busy, i_clk, i_rst_n, (o_strobe && !o_result.last) |-> busy, "walk ended early")
    `DLLS_ASSERT(a_last_idle, i_clk, i_rst_n, (o_strobe && o_result.last) |-> !busy, "busy after last result")

endmodule
